// ===== design/gpbe_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the glyph pixel blend expander
package gpbe_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CELL_W     = 3;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ADDR_W     = 19;
  localparam int unsigned SCALE_W    = 3;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned CX_W       = 10;
  localparam int unsigned CY_W       = 9;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned PROD_W     = 13;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CELL_SIZE  = 8;

  localparam logic [SCALE_W-1:0]  MAX_SCALE    = 3'd4;
  localparam logic [SCALE_W-1:0]  MIN_SCALE    = 3'd1;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 3'd2;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd400;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd240;
  localparam logic [WIDTH_W-1:0]  WIDTH_LIMIT  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 10'd512;
  localparam logic [ALPHA_W-1:0]  ALPHA_MAX    = 8'd255;
  localparam logic [ALPHA_W-1:0]  ALPHA_NONE   = 8'd0;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_BASE,
    ST_EMIT
  } gpbe_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [CELL_W-1:0]         cell_col;
    logic [CELL_W-1:0]         cell_row;
    logic [ALPHA_W-1:0]        glyph_alpha;
    logic [CELL_W-1:0]         left_shift;
    logic [PIX_W-1:0]          text_color;
    logic [PIX_W-1:0]          under_pixel;
  } gpbe_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_data;
    logic              last_write;
  } gpbe_out_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic base;
    logic load;
  } gpbe_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } gpbe_status_t;

  // floor(x / 255) for x up to 31 * 255
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {{9{1'b0}}, x[PROD_W-1:8]} + {{PROD_W{1'b0}}, 1'b1};
    return t[PROD_W-1:8];
  endfunction

endpackage

// ===== design/gpbe_in_if.sv =====
`timescale 1ns / 1ps
// input channel: one glyph source pixel per transaction
interface gpbe_in_if;
  import gpbe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [CELL_W-1:0]         cell_col;
  logic [CELL_W-1:0]         cell_row;
  logic [ALPHA_W-1:0]        glyph_alpha;
  logic [CELL_W-1:0]         left_shift;
  logic [PIX_W-1:0]          text_color;
  logic [PIX_W-1:0]          under_pixel;

  modport source (
    output valid, origin_x, origin_y, cell_col, cell_row, glyph_alpha, left_shift,
           text_color, under_pixel,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, cell_col, cell_row, glyph_alpha, left_shift,
           text_color, under_pixel,
    output ready
  );
endinterface

// ===== design/gpbe_out_if.sv =====
`timescale 1ns / 1ps
// output channel: one framebuffer write per transaction
interface gpbe_out_if;
  import gpbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [PIX_W-1:0]  write_data;
  logic              last_write;

  modport source (
    output valid, write_address, write_data, last_write,
    input  ready
  );

  modport sink (
    input  valid, write_address, write_data, last_write,
    output ready
  );
endinterface

// ===== design/gpbe_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: sequences capture, setup, address base and write issue
module gpbe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  gpbe_pkg::gpbe_status_t status_i,
  output gpbe_pkg::gpbe_cmd_t    cmd_o
);
  import gpbe_pkg::*;

  gpbe_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    // output register free or being emptied this cycle
    load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = status_i.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          cmd_o.load = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/gpbe_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, block origin, clipping, blend and address stepping
module gpbe_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gpbe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  gpbe_pkg::gpbe_in_t               in_item_i,
  input  gpbe_pkg::gpbe_cmd_t              cmd_i,
  output gpbe_pkg::gpbe_status_t           status_o,
  output gpbe_pkg::gpbe_out_t              out_item_o
);
  import gpbe_pkg::*;

  // config
  logic [SCALE_W-1:0]  scale_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [SCALE_W-1:0]  s_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  // captured item
  logic signed [POS_W-1:0] bx_q, by_q, bx_d, by_d;
  logic [ALPHA_W-1:0]      alpha_q;
  logic [PIX_W-1:0]        color_q, under_q;
  logic signed [3:0]       dcol;
  logic signed [POS_W-1:0] xoff;
  logic [5:0]              yoff;

  // setup stage
  logic signed [POS_W-1:0] w_s, h_s, s_s, x_end, y_end, x_lo, x_hi, y_lo, y_hi;
  logic                    vis, empty_d, empty_q;
  logic [PIX_W-1:0]        bg;
  logic [ALPHA_W-1:0]      inv_alpha;
  logic [CH_W-1:0]         col_ch [NUM_CH];
  logic [CH_W-1:0]         bg_ch  [NUM_CH];
  logic [PROD_W-1:0]       pc_q [NUM_CH];
  logic [PROD_W-1:0]       pb_q [NUM_CH];
  logic [CX_W-1:0]         x_lo_q, x_hi_q;
  logic [CY_W-1:0]         y_lo_q, y_hi_q;

  // base stage and stepping
  logic [CH_W-1:0]     mix [NUM_CH];
  logic [PIX_W-1:0]    data_d, data_q;
  logic [ADDR_W-1:0]   base_addr, addr_q, row_addr_q;
  logic [HEIGHT_W-1:0] row_off;
  logic [CX_W-1:0]     cx_q;
  logic [CY_W-1:0]     cy_q;
  logic                last;
  gpbe_out_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_q == '0) begin
      s_eff = MIN_SCALE;
    end else if (scale_q > MAX_SCALE) begin
      s_eff = MAX_SCALE;
    end else begin
      s_eff = scale_q;
    end
  end

  assign w_eff = (width_q > WIDTH_LIMIT) ? WIDTH_LIMIT : width_q;
  assign h_eff = (height_q > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_q;

  // block origin from cell position
  assign dcol = $signed({1'b0, in_item_i.cell_col}) - $signed({1'b0, in_item_i.left_shift});
  assign xoff = POS_W'(dcol) * $signed(POS_W'(s_eff));
  assign yoff = 6'(in_item_i.cell_row) * 6'(s_eff);
  assign bx_d = POS_W'(in_item_i.origin_x) + xoff;
  assign by_d = POS_W'(in_item_i.origin_y) + $signed(POS_W'(yoff));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bx_q    <= bx_d;
      by_q    <= by_d;
      alpha_q <= in_item_i.glyph_alpha;
      color_q <= in_item_i.text_color;
      under_q <= in_item_i.under_pixel;
    end
  end

  // clip window and background visibility
  assign w_s   = $signed(POS_W'(w_eff));
  assign h_s   = $signed(POS_W'(h_eff));
  assign s_s   = $signed(POS_W'(s_eff));
  assign x_end = bx_q + s_s - POS_W'(1);
  assign y_end = by_q + s_s - POS_W'(1);
  assign x_lo  = bx_q[POS_W-1] ? '0 : bx_q;
  assign y_lo  = by_q[POS_W-1] ? '0 : by_q;
  assign x_hi  = (x_end < w_s - POS_W'(1)) ? x_end : w_s - POS_W'(1);
  assign y_hi  = (y_end < h_s - POS_W'(1)) ? y_end : h_s - POS_W'(1);
  assign vis   = !bx_q[POS_W-1] && (bx_q < w_s) && !by_q[POS_W-1] && (by_q < h_s);
  assign bg    = vis ? under_q : '0;
  assign inv_alpha = ALPHA_MAX - alpha_q;
  assign empty_d   = (alpha_q == ALPHA_NONE) || (x_lo > x_hi) || (y_lo > y_hi);

  // red, green upper five bits, blue
  assign col_ch[0] = color_q[15:11];
  assign col_ch[1] = color_q[10:6];
  assign col_ch[2] = color_q[4:0];
  assign bg_ch[0]  = bg[15:11];
  assign bg_ch[1]  = bg[10:6];
  assign bg_ch[2]  = bg[4:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      for (int i = 0; i < NUM_CH; i++) begin
        pc_q[i] <= PROD_W'(col_ch[i]) * PROD_W'(alpha_q);
        pb_q[i] <= PROD_W'(bg_ch[i]) * PROD_W'(inv_alpha);
      end
      x_lo_q <= x_lo[CX_W-1:0];
      x_hi_q <= x_hi[CX_W-1:0];
      y_lo_q <= y_lo[CY_W-1:0];
      y_hi_q <= y_hi[CY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.prep) begin
      empty_q <= empty_d;
    end
  end

  // channel sums never exceed five bits
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mix[i] = div255(pc_q[i]) + div255(pb_q[i]);
    end
  end

  assign data_d    = (alpha_q == ALPHA_MAX) ? color_q : {mix[0], mix[1], 1'b0, mix[2]};
  assign row_off   = h_eff - HEIGHT_W'(1) - HEIGHT_W'(y_lo_q);
  assign base_addr = ADDR_W'(x_lo_q) * ADDR_W'(h_eff) + ADDR_W'(row_off);
  assign last      = (cx_q == x_hi_q) && (cy_q == y_hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      data_q     <= data_d;
      addr_q     <= base_addr;
      row_addr_q <= base_addr;
      cx_q       <= x_lo_q;
      cy_q       <= y_lo_q;
    end else if (cmd_i.load) begin
      out_q.write_address <= addr_q;
      out_q.write_data    <= data_q;
      out_q.last_write    <= last;
      if (cx_q == x_hi_q) begin
        // next block row, one step down the rotated column
        cx_q       <= x_lo_q;
        cy_q       <= cy_q + CY_W'(1);
        row_addr_q <= row_addr_q - ADDR_W'(1);
        addr_q     <= row_addr_q - ADDR_W'(1);
      end else begin
        cx_q   <= cx_q + CX_W'(1);
        addr_q <= addr_q + ADDR_W'(h_eff);
      end
    end
  end

  assign status_o.empty = empty_q;
  assign status_o.last  = last;
  assign out_item_o     = out_q;

endmodule

// ===== design/glyph_pixel_blend_expander.sv =====
`timescale 1ns / 1ps
// first write: after the input transaction the block passes its setup and base address
//   states, then registers one write per cycle on the output while the sink takes them
// input: no new source pixel is taken until the n visible writes (up to scale squared)
//   of the last one are issued by the single address stepper
// reset: asynchronous active low, idle with no write pending, scale 2, 400 x 240 screen
// top level: glyph pixel blend and scale expansion into a rotated framebuffer
module glyph_pixel_blend_expander (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gpbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gpbe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gpbe_in_if.sink                         in_i,
  gpbe_out_if.source                      out_o
);
  import gpbe_pkg::*;

  gpbe_in_t     in_item;
  gpbe_out_t    out_item;
  gpbe_cmd_t    cmd;
  gpbe_status_t status;

  // pack the incoming transaction for the datapath
  assign in_item.origin_x    = in_i.origin_x;
  assign in_item.origin_y    = in_i.origin_y;
  assign in_item.cell_col    = in_i.cell_col;
  assign in_item.cell_row    = in_i.cell_row;
  assign in_item.glyph_alpha = in_i.glyph_alpha;
  assign in_item.left_shift  = in_i.left_shift;
  assign in_item.text_color  = in_i.text_color;
  assign in_item.under_pixel = in_i.under_pixel;

  // controller: idle / setup / base address / write issue, owns the output valid
  gpbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: origin, clip window, channel blend, address walk and output register
  gpbe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item)
  );

  // output register contents, valid comes from the controller
  assign out_o.write_address = out_item.write_address;
  assign out_o.write_data    = out_item.write_data;
  assign out_o.last_write    = out_item.last_write;

endmodule

// ===== design/gpbe_checker.sv =====
`timescale 1ns / 1ps
// port level checker for the glyph pixel blend expander, bound to the top level
module gpbe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [gpbe_pkg::ALPHA_W-1:0]  in_alpha_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [gpbe_pkg::ADDR_W-1:0]   out_address_i,
  input logic [gpbe_pkg::PIX_W-1:0]    out_data_i,
  input logic                          out_last_i
);
  import gpbe_pkg::*;

  // a transaction closes the input until its writes are issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  // a transparent pixel comes back idle without writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_alpha_i == ALPHA_NONE) |-> ##3 in_ready_i)
    else $error("transparent pixel did not return to idle");

  // while a write other than the last is pending the block is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready before the last write");

  // stalled write holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_address_i)
      && $stable(out_data_i) && $stable(out_last_i))
    else $error("stalled write changed");

endmodule

bind glyph_pixel_blend_expander gpbe_checker u_gpbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_alpha_i    (in_i.glyph_alpha),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_address_i (out_o.write_address),
  .out_data_i    (out_o.write_data),
  .out_last_i    (out_o.last_write)
);

// ===== dv/tb_glyph_pixel_blend_expander.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the glyph pixel blend expander: directed and random pixels
module tb_glyph_pixel_blend_expander;
  import gpbe_pkg::*;

  // cycles the sink holds off while the source keeps offering pixels
  localparam int HOLD_CYCLES    = 300;
  // quiet cycles after the last expected write, covers a pixel that writes nothing
  localparam int SETTLE_CYCLES  = 12;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  // expected framebuffer writes, with a private copy of the register settings
  class blend_scoreboard;
    gpbe_out_t           writes_due[$];
    logic [SCALE_W-1:0]  scale;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    int                  errors;

    function new();
      scale  = SCALE_RESET;
      width  = WIDTH_RESET;
      height = HEIGHT_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SCALE:  scale  = val[SCALE_W-1:0];
        REG_WIDTH:  width  = val[WIDTH_W-1:0];
        REG_HEIGHT: height = val[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // scale the three 5-bit channels by a/255, green taken from bits 10..6
    function int unsigned weigh(int unsigned pix, int unsigned a);
      int unsigned r, g, b;
      r = (pix >> 11) & 31;
      g = (pix >> 6) & 31;
      b = pix & 31;
      return ((r * a / 255) << 11) | ((g * a / 255) << 6) | (b * a / 255);
    endfunction

    // blend one source pixel and expand it into the clipped block of writes
    function void note_pixel(gpbe_in_t px);
      gpbe_out_t   blk[$];
      gpbe_out_t   wr;
      int          s, w, h, bx, by, cx, cy;
      int unsigned a, bg, data, addr;
      s = int'(scale);
      if (s < int'(MIN_SCALE)) s = int'(MIN_SCALE);
      if (s > int'(MAX_SCALE)) s = int'(MAX_SCALE);
      w = (width > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(width);
      h = (height > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(height);
      if (px.glyph_alpha == ALPHA_NONE) return;
      bx = int'($signed(px.origin_x)) + (int'(px.cell_col) - int'(px.left_shift)) * s;
      by = int'($signed(px.origin_y)) + int'(px.cell_row) * s;
      a  = 32'(px.glyph_alpha);
      if (px.glyph_alpha == ALPHA_MAX) begin
        data = 32'(px.text_color);
      end else begin
        // background only counts when the block's first pixel is on screen
        bg   = (bx >= 0 && bx < w && by >= 0 && by < h) ? 32'(px.under_pixel) : 0;
        data = (weigh(32'(px.text_color), a) + weigh(bg, ALPHA_MAX - a)) & 'hffff;
      end
      for (int sy = 0; sy < s; sy++) begin
        cy = by + sy;
        if (cy >= 0 && cy < h) begin
          for (int sx = 0; sx < s; sx++) begin
            cx = bx + sx;
            if (cx >= 0 && cx < w) begin
              addr             = cx * h + (h - 1 - cy);
              wr.write_address = addr[ADDR_W-1:0];
              wr.write_data    = data[PIX_W-1:0];
              wr.last_write    = 1'b0;
              blk.push_back(wr);
            end
          end
        end
      end
      if (blk.size() > 0) begin
        wr = blk.pop_back();
        wr.last_write = 1'b1;
        blk.push_back(wr);
      end
      foreach (blk[i]) writes_due.push_back(blk[i]);
    endfunction

    function void check_write(gpbe_out_t got);
      gpbe_out_t want;
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected write, expected none, got address %0d data %h last %0d",
                 $time, got.write_address, got.write_data, got.last_write);
        errors++;
        return;
      end
      want = writes_due.pop_front();
      if (got.write_address !== want.write_address) begin
        $display("%0t: write_address mismatch, expected %0d, got %0d",
                 $time, want.write_address, got.write_address);
        errors++;
      end
      if (got.write_data !== want.write_data) begin
        $display("%0t: write_data mismatch, expected %h, got %h",
                 $time, want.write_data, got.write_data);
        errors++;
      end
      if (got.last_write !== want.last_write) begin
        $display("%0t: last_write mismatch, expected %0d, got %0d",
                 $time, want.last_write, got.last_write);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  hold_req;
  int                    burst_left;
  int                    idle_cycles;

  blend_scoreboard sb = new();

  gpbe_in_if  in_if ();
  gpbe_out_if out_if ();

  glyph_pixel_blend_expander dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // source side: bursts of random length separated by random gaps,
  // returns at the edge where the pixel transaction is taken
  task automatic push_pixel(input gpbe_in_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.origin_x    <= px.origin_x;
    in_if.origin_y    <= px.origin_y;
    in_if.cell_col    <= px.cell_col;
    in_if.cell_row    <= px.cell_row;
    in_if.glyph_alpha <= px.glyph_alpha;
    in_if.left_shift  <= px.left_shift;
    in_if.text_color  <= px.text_color;
    in_if.under_pixel <= px.under_pixel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic offer_pixel(input int ox, input int oy, input int col, input int row,
                             input int a, input int sh, input int color, input int under);
    gpbe_in_t px;
    px.origin_x    = COORD_W'(ox);
    px.origin_y    = COORD_W'(oy);
    px.cell_col    = CELL_W'(col);
    px.cell_row    = CELL_W'(row);
    px.glyph_alpha = ALPHA_W'(a);
    px.left_shift  = CELL_W'(sh);
    px.text_color  = PIX_W'(color);
    px.under_pixel = PIX_W'(under);
    push_pixel(px);
  endtask

  // mostly cells placed around the visible screen, one in ten pure noise
  function automatic gpbe_in_t random_pixel();
    gpbe_in_t px;
    int       w, h, x, y;
    px.origin_x    = COORD_W'($urandom);
    px.origin_y    = COORD_W'($urandom);
    px.cell_col    = CELL_W'($urandom);
    px.cell_row    = CELL_W'($urandom);
    px.glyph_alpha = ALPHA_W'($urandom);
    px.left_shift  = CELL_W'($urandom);
    px.text_color  = PIX_W'($urandom);
    px.under_pixel = PIX_W'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      w = (sb.width > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(sb.width);
      h = (sb.height > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(sb.height);
      x = $urandom_range(0, w + 40);
      y = $urandom_range(0, h + 40);
      px.origin_x = COORD_W'(x - 24);
      px.origin_y = COORD_W'(y - 24);
      // lean on the alpha corner cases: transparent, opaque, one step from each
      case ($urandom_range(0, 7))
        0: px.glyph_alpha = ALPHA_NONE;
        1: px.glyph_alpha = ALPHA_MAX;
        2: px.glyph_alpha = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
        default: ;
      endcase
    end
    return px;
  endfunction

  // drop valid, wait for every expected write, then let the pipe go quiet;
  // one edge first so the monitor has booked the last accepted pixel
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.writes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // all three registers, one write per cycle, only while the block is idle
  task automatic write_regs(input int s, input int w, input int h);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{REG_SCALE, REG_WIDTH, REG_HEIGHT};
    val = '{CFG_DATA_W'(s), CFG_DATA_W'(w), CFG_DATA_W'(h)};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random pixels, optionally with a long sink hold-off a third of the way in
  task automatic run_random(input int count, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1'b1;
      push_pixel(random_pixel());
    end
    settle();
  endtask

  // sink side: alternating runs of ready and stall, long runs now and then,
  // plus a counted hold-off on request to back the block up
  initial begin : sink_pacing
    int hold_left;
    int run_left;
    bit run_high;
    hold_left = 0;
    run_left  = 0;
    run_high  = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        if (hold_left == 0) hold_left = HOLD_CYCLES;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_high = !run_high;
          if (run_high) run_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
          else run_left = $urandom_range(1, 6);
        end
        run_left--;
        out_if.ready <= run_high;
      end
    end
  end

  // transaction monitor and watchdog, sampled on the rising edge
  always @(posedge clk_i) begin
    gpbe_in_t  seen;
    gpbe_out_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen.origin_x    = in_if.origin_x;
        seen.origin_y    = in_if.origin_y;
        seen.cell_col    = in_if.cell_col;
        seen.cell_row    = in_if.cell_row;
        seen.glyph_alpha = in_if.glyph_alpha;
        seen.left_shift  = in_if.left_shift;
        seen.text_color  = in_if.text_color;
        seen.under_pixel = in_if.under_pixel;
        sb.note_pixel(seen);
      end
      if (out_if.valid && out_if.ready) begin
        got.write_address = out_if.write_address;
        got.write_data    = out_if.write_data;
        got.last_write    = out_if.last_write;
        sb.check_write(got);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= REG_SCALE;
    cfg_data_i        <= '0;
    in_if.valid       <= 1'b0;
    in_if.origin_x    <= '0;
    in_if.origin_y    <= '0;
    in_if.cell_col    <= '0;
    in_if.cell_row    <= '0;
    in_if.glyph_alpha <= '0;
    in_if.left_shift  <= '0;
    in_if.text_color  <= '0;
    in_if.under_pixel <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed at the reset settings: scale 2 on a 400 x 240 screen
    offer_pixel(10, 10, 0, 0, 0, 0, 'hffff, 'hffff);         // transparent, no writes
    offer_pixel(0, 0, 0, 0, 255, 0, 'hffff, 'h0000);         // opaque at the top-left corner
    offer_pixel(20, 30, 3, 4, 128, 1, 'hf800, 'h07e0);       // half blend over visible background
    offer_pixel(20, 30, 7, 7, 1, 0, 'hffff, 'hffff);         // faintest coverage
    offer_pixel(20, 30, 0, 0, 254, 7, 'h001f, 'hffc0);       // near-opaque, widest left bearing
    offer_pixel(-1, 5, 0, 0, 200, 0, 'hffff, 'hffff);        // first pixel off the left edge
    offer_pixel(5, -1, 0, 0, 90, 0, 'h7bef, 'hffff);         // first pixel off the top edge
    offer_pixel(399, 239, 0, 0, 100, 0, 'h1234, 'habcd);     // one pixel left after clipping
    offer_pixel(398, 238, 0, 0, 255, 0, 'habcd, 'h0000);     // full block in the far corner
    offer_pixel(-2048, -2048, 7, 7, 77, 0, 'hffff, 'hffff);  // most negative origin
    offer_pixel(2047, 2047, 7, 7, 255, 7, 'hffff, 'hffff);   // most positive origin
    offer_pixel(0, 0, 0, 0, 1, 7, 'h0000, 'hffff);           // bearing pushes block off screen
    offer_pixel(100, 100, 5, 2, 255, 3, 'h0000, 'hffff);     // opaque black
    settle();
    run_random(40, 1'b0);

    // largest scale and screen, blocks at the bottom-right screen corner
    write_regs(4, 1024, 512);
    offer_pixel(1020, 508, 0, 0, 255, 0, 'h5a5a, 'h0000);
    offer_pixel(1020, 508, 0, 0, 77, 0, 'h1234, 'hfedc);
    offer_pixel(30, 10, 0, 7, 150, 7, 'hffff, 'h8410);
    run_random(60, 1'b1);

    write_regs(1, 400, 240);
    run_random(50, 1'b0);

    // out-of-range values: scale 0 acts as 1, sizes clamp to their limits
    write_regs(0, 2047, 1023);
    run_random(50, 1'b0);

    // scale above the maximum on a small screen, with a second hold-off
    write_regs(7, 64, 48);
    run_random(60, 1'b1);

    write_regs(3, 1, 1);
    run_random(25, 1'b0);

    // zero width clips every write
    write_regs(5, 0, 512);
    run_random(15, 1'b0);

    write_regs(2, 320, 1);
    run_random(30, 1'b0);

    if (sb.errors == 0 && sb.writes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
